FILE: hw/rtl/hsd_pkg.sv
`default_nettype none

package hsd_pkg;

	localparam int BYTE_W      = 8;
	localparam int LEN_W       = 7;
	localparam int IDX_W       = 6;
	localparam int CNT_W       = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 8;
	localparam int MAX_PAYLOAD_DEF = 64;
	localparam int LEN_RESET   = 64;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HDR_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HDR_SECOND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAY_LEN    = 2'd2;

	// Deframer phase codes
	localparam int PHASE_W = 2;
	localparam logic [PHASE_W-1:0] PH_HUNT  = 2'd0;
	localparam logic [PHASE_W-1:0] PH_LOAD  = 2'd1;
	localparam logic [PHASE_W-1:0] PH_CHECK = 2'd2;

	typedef struct packed {
		logic [BYTE_W-1:0] first;
		logic [BYTE_W-1:0] second;
	} hdr_cfg_t;

	typedef struct packed {
		logic              payload_strobe;
		logic [BYTE_W-1:0] payload_byte;
		logic [IDX_W-1:0]  payload_index;
		logic              frame_done;
		logic              frame_ok;
		logic [CNT_W-1:0]  good_frames;
	} res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/hsd_if.sv
`default_nettype none

interface hsd_rx_if;
	import hsd_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hsd_res_if;
	import hsd_pkg::*;
	logic              valid;
	logic              ready;
	logic              payload_strobe;
	logic [BYTE_W-1:0] payload_byte;
	logic [IDX_W-1:0]  payload_index;
	logic              frame_done;
	logic              frame_ok;
	logic [CNT_W-1:0]  good_frames;

	modport source (output valid, output payload_strobe, output payload_byte,
		output payload_index, output frame_done, output frame_ok,
		output good_frames, input ready);
	modport sink   (input valid, input payload_strobe, input payload_byte,
		input payload_index, input frame_done, input frame_ok,
		input good_frames, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/hsd_cfg.sv
`default_nettype none

module hsd_cfg #(
	parameter int MAX_PAYLOAD = hsd_pkg::MAX_PAYLOAD_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [hsd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [hsd_pkg::CFG_DATA_W-1:0]   cfg_data,
	output hsd_pkg::hdr_cfg_t                     hdr,
	output logic [$clog2(MAX_PAYLOAD+1)-1:0]      eff_len
);
	import hsd_pkg::*;

	localparam int POS_W = $clog2(MAX_PAYLOAD + 1);
	localparam int CMP_W = (POS_W > LEN_W) ? POS_W : LEN_W;

	hdr_cfg_t         hdr_q;
	logic [LEN_W-1:0] len_q;
	logic [CMP_W-1:0] len_ext;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q <= '0;
			len_q <= LEN_W'(LEN_RESET);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HDR_FIRST:  hdr_q.first  <= cfg_data[BYTE_W-1:0];
				REG_HDR_SECOND: hdr_q.second <= cfg_data[BYTE_W-1:0];
				REG_PAY_LEN:    len_q        <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the length to 1..MAX_PAYLOAD
	always_comb begin
		len_ext = CMP_W'(len_q);
		if (len_q == '0)
			eff_len = POS_W'(1);
		else if (len_ext > CMP_W'(MAX_PAYLOAD))
			eff_len = POS_W'(MAX_PAYLOAD);
		else
			eff_len = POS_W'(len_ext);
	end

	assign hdr = hdr_q;

endmodule

`default_nettype wire

FILE: hw/rtl/hsd_core.sv
`default_nettype none

module hsd_core #(
	parameter int MAX_PAYLOAD = hsd_pkg::MAX_PAYLOAD_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          accept,
	input  wire logic [hsd_pkg::BYTE_W-1:0]    rx_byte,
	input  wire hsd_pkg::hdr_cfg_t             hdr,
	input  wire logic [$clog2(MAX_PAYLOAD+1)-1:0] eff_len,
	output hsd_pkg::res_t                      res
);
	import hsd_pkg::*;

	localparam int POS_W = $clog2(MAX_PAYLOAD + 1);

	logic [PHASE_W-1:0] phase_q, phase_d;
	logic [BYTE_W-1:0]  prev_q;
	logic [POS_W-1:0]   pos_q, pos_d, pos_inc;
	logic [BYTE_W-1:0]  sum_q, sum_d;
	logic [CNT_W-1:0]   good_q, good_d;

	assign pos_inc = pos_q + POS_W'(1);

	// Next state and result for the byte at the input
	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		sum_d   = sum_q;
		good_d  = good_q;
		res     = '0;
		unique case (phase_q)
			PH_HUNT: begin
				if (prev_q == hdr.first && rx_byte == hdr.second) begin
					pos_d   = '0;
					sum_d   = '0;
					phase_d = PH_LOAD;
				end
			end
			PH_LOAD: begin
				res.payload_strobe = 1'b1;
				res.payload_byte   = rx_byte;
				res.payload_index  = IDX_W'(pos_q);
				sum_d = sum_q + rx_byte;
				pos_d = pos_inc;
				if (pos_inc >= eff_len)
					phase_d = PH_CHECK;
			end
			PH_CHECK: begin
				res.frame_done = 1'b1;
				if (sum_q == rx_byte) begin
					res.frame_ok = 1'b1;
					good_d = good_q + CNT_W'(1);
				end
				pos_d   = '0;
				sum_d   = '0;
				phase_d = PH_HUNT;
			end
			default: begin
				pos_d   = '0;
				sum_d   = '0;
				phase_d = PH_HUNT;
			end
		endcase
		res.good_frames = good_d;
	end

	// Advance state on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			prev_q  <= '0;
			pos_q   <= '0;
			sum_q   <= '0;
			good_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			prev_q  <= rx_byte;
			pos_q   <= pos_d;
			sum_q   <= sum_d;
			good_q  <= good_d;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/header_sum8_frame_deframer_top.sv
// A result is registered and offered in the cycle after its byte is transferred in.
// Throughput: one byte per cycle while the result side is ready; the single
// output register refills in the same cycle its result is transferred out.
// Reset: arst_n clears deframer state, the good-frame count and the output
// valid; header bytes reset to 0 and the payload length to 64.
`default_nettype none

module header_sum8_frame_deframer_top #(
	parameter int MAX_PAYLOAD = hsd_pkg::MAX_PAYLOAD_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	hsd_rx_if.sink                              rx_ch,
	hsd_res_if.source                           res_ch,
	input  wire logic                           cfg_we,
	input  wire logic [hsd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [hsd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import hsd_pkg::*;

	localparam int POS_W = $clog2(MAX_PAYLOAD + 1);

	hdr_cfg_t         hdr;
	logic [POS_W-1:0] eff_len;
	res_t             res_d, res_q;
	logic             valid_q;
	logic             accept;

	hsd_cfg #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.hdr       (hdr),
		.eff_len   (eff_len)
	);

	hsd_core #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (rx_ch.rx_byte),
		.hdr     (hdr),
		.eff_len (eff_len),
		.res     (res_d)
	);

	// Take a byte whenever the output register is empty or draining
	assign rx_ch.ready = !valid_q || res_ch.ready;
	assign accept      = rx_ch.valid && rx_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (rx_ch.ready) begin
			valid_q <= rx_ch.valid;
		end
	end

	// Load the result register on each input transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end
	end

	assign res_ch.valid          = valid_q;
	assign res_ch.payload_strobe = res_q.payload_strobe;
	assign res_ch.payload_byte   = res_q.payload_byte;
	assign res_ch.payload_index  = res_q.payload_index;
	assign res_ch.frame_done     = res_q.frame_done;
	assign res_ch.frame_ok       = res_q.frame_ok;
	assign res_ch.good_frames    = res_q.good_frames;

endmodule

`default_nettype wire

FILE: hw/rtl/hsd_checker.sv
`default_nettype none

module hsd_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        res_valid,
	input wire logic                        res_ready,
	input wire logic                        payload_strobe,
	input wire logic [hsd_pkg::BYTE_W-1:0]  payload_byte,
	input wire logic [hsd_pkg::IDX_W-1:0]   payload_index,
	input wire logic                        frame_done,
	input wire logic                        frame_ok,
	input wire logic [hsd_pkg::CNT_W-1:0]   good_frames
);
	import hsd_pkg::*;

	// A byte is either payload or checksum, never both
	a_strobe_done_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(payload_strobe && frame_done))
		else $error("payload strobe and frame done together");

	// A good frame is always a finished frame
	a_ok_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && frame_ok) |-> frame_done)
		else $error("frame ok without frame done");

	// Quiet payload fields outside payload bytes
	a_quiet_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !payload_strobe) |-> (payload_byte == '0 && payload_index == '0))
		else $error("payload fields not zero without strobe");

	// Hold a stalled result
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(good_frames)
			&& $stable(payload_byte) && $stable(frame_done)))
		else $error("stalled result changed");

endmodule

bind header_sum8_frame_deframer_top hsd_checker u_hsd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (res_ch.valid),
	.res_ready      (res_ch.ready),
	.payload_strobe (res_ch.payload_strobe),
	.payload_byte   (res_ch.payload_byte),
	.payload_index  (res_ch.payload_index),
	.frame_done     (res_ch.frame_done),
	.frame_ok       (res_ch.frame_ok),
	.good_frames    (res_ch.good_frames)
);

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import hsd_pkg::*;

	localparam int                   CYCLE_LIMIT  = 200_000;
	localparam int                   SETTLE_WAIT  = 4;
	localparam int                   HOLD_CYCLES  = 150;
	localparam int                   MIN_FRAMES   = 10;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 2'd3;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	hsd_rx_if  rx_ch();
	hsd_res_if res_ch();

	header_sum8_frame_deframer_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_ch     (rx_ch),
		.res_ch    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow copy of the configuration registers
	logic [BYTE_W-1:0] hdr_first_cfg;
	logic [BYTE_W-1:0] hdr_second_cfg;
	logic [LEN_W-1:0]  len_cfg;

	// Shadow copy of the deframer state
	logic [PHASE_W-1:0] frm_phase;
	logic [BYTE_W-1:0]  frm_prev;
	logic [LEN_W-1:0]   frm_pos;
	logic [BYTE_W-1:0]  frm_sum;
	logic [CNT_W-1:0]   frm_good;

	res_t pending_results[$];

	int  cycle_count;
	int  error_count;
	int  bytes_sent;
	int  results_seen;
	int  frames_closed;
	int  frames_good;
	bit  src_idle_en;
	bit  sink_idle_en;
	int  sink_hold;

	// Clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Give up on a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_results.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic logic [LEN_W-1:0] eff_len();
		if (len_cfg == '0)
			return LEN_W'(1);
		if (len_cfg > LEN_W'(MAX_PAYLOAD_DEF))
			return LEN_W'(MAX_PAYLOAD_DEF);
		return len_cfg;
	endfunction

	// Advance the shadow deframer by one byte and return its result
	function automatic res_t deframe_byte(logic [BYTE_W-1:0] b);
		res_t r;
		r = '0;
		case (frm_phase)
			PH_HUNT: begin
				if (frm_prev == hdr_first_cfg && b == hdr_second_cfg) begin
					frm_pos   = '0;
					frm_sum   = '0;
					frm_phase = PH_LOAD;
				end
			end
			PH_LOAD: begin
				r.payload_strobe = 1'b1;
				r.payload_byte   = b;
				r.payload_index  = frm_pos[IDX_W-1:0];
				frm_sum = frm_sum + b;
				frm_pos = frm_pos + LEN_W'(1);
				if (frm_pos >= eff_len())
					frm_phase = PH_CHECK;
			end
			PH_CHECK: begin
				r.frame_done = 1'b1;
				if (frm_sum == b) begin
					r.frame_ok = 1'b1;
					frm_good   = frm_good + CNT_W'(1);
				end
				frm_pos   = '0;
				frm_sum   = '0;
				frm_phase = PH_HUNT;
			end
			default: begin
				frm_pos   = '0;
				frm_sum   = '0;
				frm_phase = PH_HUNT;
			end
		endcase
		frm_prev      = b;
		r.good_frames = frm_good;
		return r;
	endfunction

	// Check each result transfer against the oldest prediction,
	// then predict the input transfer
	always @(posedge clk) begin : scoreboard
		res_t got;
		res_t want;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				got.payload_strobe = res_ch.payload_strobe;
				got.payload_byte   = res_ch.payload_byte;
				got.payload_index  = res_ch.payload_index;
				got.frame_done     = res_ch.frame_done;
				got.frame_ok       = res_ch.frame_ok;
				got.good_frames    = res_ch.good_frames;
				results_seen++;
				if (pending_results.size() == 0) begin
					error_count++;
					if (error_count <= 10)
						$display({"%0t: result with nothing expected: ",
							"strobe=%b byte=%h idx=%0d done=%b ok=%b good=%0d"},
							$realtime, got.payload_strobe, got.payload_byte,
							got.payload_index, got.frame_done, got.frame_ok,
							got.good_frames);
				end else begin
					want = pending_results.pop_front();
					if (want.frame_done) begin
						frames_closed++;
						if (want.frame_ok)
							frames_good++;
					end
					if (got !== want) begin
						error_count++;
						if (error_count <= 10) begin
							$display("%0t: mismatch on result %0d", $realtime, results_seen);
							$display("  expected strobe=%b byte=%h idx=%0d done=%b ok=%b good=%0d",
								want.payload_strobe, want.payload_byte, want.payload_index,
								want.frame_done, want.frame_ok, want.good_frames);
							$display("  actual   strobe=%b byte=%h idx=%0d done=%b ok=%b good=%0d",
								got.payload_strobe, got.payload_byte, got.payload_index,
								got.frame_done, got.frame_ok, got.good_frames);
						end
					end
				end
			end
			if (rx_ch.valid && rx_ch.ready)
				pending_results.push_back(deframe_byte(rx_ch.rx_byte));
		end
	end

	// Result side: random stalls, or a long hold-off when requested
	always @(posedge clk) begin
		if (sink_hold > 0) begin
			res_ch.ready <= 1'b0;
			sink_hold--;
		end else if (sink_idle_en) begin
			res_ch.ready <= ($urandom_range(0, 99) >= 31);
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	// Offer one byte and hold it until transfer
	task automatic send_rx_byte(input logic [BYTE_W-1:0] b);
		while (src_idle_en && $urandom_range(0, 99) < 31) begin
			rx_ch.valid <= 1'b0;
			@(posedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	// Drop valid, drain every pending result, then let the pipeline go quiet
	task automatic settle();
		rx_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_HDR_FIRST:  hdr_first_cfg  = data;
			REG_HDR_SECOND: hdr_second_cfg = data;
			REG_PAY_LEN:    len_cfg        = data[LEN_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Send one frame at the current setting;
	// chain forces the sum to equal the first header byte
	task automatic send_frame(input bit with_first, input bit corrupt, input bit chain);
		logic [BYTE_W-1:0] s;
		logic [BYTE_W-1:0] b;
		int n;
		n = int'(eff_len());
		s = '0;
		if (with_first)
			send_rx_byte(hdr_first_cfg);
		send_rx_byte(hdr_second_cfg);
		for (int i = 0; i < n; i++) begin
			b = BYTE_W'($urandom);
			if (chain && i == n - 1)
				b = hdr_first_cfg - s;
			s = s + b;
			send_rx_byte(b);
		end
		b = corrupt ? (s ^ BYTE_W'($urandom_range(1, 255))) : s;
		send_rx_byte(b);
	endtask

	// Reset values; first byte 0 opens a frame at once, length then drops mid-frame
	task automatic test_defaults_and_length_change();
		send_rx_byte(8'h00);
		send_rx_byte(8'h12);
		send_rx_byte(8'hFE);
		settle();
		cfg_write(REG_PAY_LEN, 8'd1);
		send_rx_byte(8'h07);
		send_rx_byte(8'h17);
		settle();
	endtask

	// Length zero acts as one; a write to the spare index changes nothing
	task automatic test_zero_length();
		cfg_write(REG_HDR_FIRST, 8'hA5);
		cfg_write(REG_HDR_SECOND, 8'h5A);
		cfg_write(REG_PAY_LEN, 8'd0);
		cfg_write(REG_UNUSED, 8'h99);
		send_rx_byte(8'hA5);
		send_rx_byte(8'h5A);
		send_rx_byte(8'hFF);
		send_rx_byte(8'hFF);
		settle();
	endtask

	// False start, back-to-back frames, header bytes inside payload, bad checksum
	task automatic test_back_to_back();
		cfg_write(REG_HDR_FIRST, 8'h3C);
		cfg_write(REG_HDR_SECOND, 8'hC3);
		cfg_write(REG_PAY_LEN, 8'd2);
		send_rx_byte(8'h3C);
		send_rx_byte(8'h11);
		send_rx_byte(8'h3C);
		send_rx_byte(8'hC3);
		send_rx_byte(8'h3C);
		send_rx_byte(8'h00);
		send_rx_byte(8'h3C);
		send_rx_byte(8'hC3);
		send_rx_byte(8'h3C);
		send_rx_byte(8'hC3);
		send_rx_byte(8'h00);
		settle();
	endtask

	// One setting: mostly whole frames with random content, plus noise and broken frames
	task automatic run_phase(input logic [BYTE_W-1:0] first, input logic [BYTE_W-1:0] second,
			input logic [CFG_DATA_W-1:0] len_val, input int budget, input bit idle,
			input bit hold);
		int  stop_at;
		int  kind;
		bit  chained;
		int  k;
		settle();
		cfg_write(REG_HDR_FIRST, first);
		cfg_write(REG_HDR_SECOND, second);
		cfg_write(REG_PAY_LEN, len_val);
		src_idle_en  = idle;
		sink_idle_en = idle;
		if (hold)
			sink_hold = HOLD_CYCLES;
		stop_at = bytes_sent + budget;
		chained = 1'b0;
		while (bytes_sent < stop_at) begin
			kind = $urandom_range(0, 99);
			if (kind < 55) begin
				k = $urandom_range(0, 3);
				send_frame(!chained, 1'b0, k == 0);
				chained = (k == 0);
			end else if (kind < 70) begin
				send_frame(!chained, 1'b1, 1'b0);
				chained = 1'b0;
			end else if (kind < 82) begin
				repeat ($urandom_range(1, 4))
					send_rx_byte(BYTE_W'($urandom));
				chained = 1'b0;
			end else if (kind < 92) begin
				send_rx_byte(hdr_first_cfg);
				send_rx_byte(hdr_second_cfg ^ BYTE_W'($urandom_range(1, 255)));
				chained = 1'b0;
			end else begin
				send_rx_byte(hdr_first_cfg);
				send_rx_byte(hdr_second_cfg);
				repeat ($urandom_range(0, int'(eff_len()) - 1))
					send_rx_byte(BYTE_W'($urandom));
				chained = 1'b0;
			end
		end
	endtask

	task automatic test_random_traffic();
		run_phase(BYTE_W'($urandom), BYTE_W'($urandom), 8'($urandom_range(1, 6)),
			120, 1'b1, 1'b0);
		run_phase(8'h00, 8'hFF, 8'd1, 80, 1'b0, 1'b0);
		run_phase(8'hFF, 8'h00, 8'd64, 130, 1'b1, 1'b1);
		run_phase(BYTE_W'($urandom), BYTE_W'($urandom), 8'h80, 60, 1'b1, 1'b0);
		run_phase(8'h55, 8'h55, 8'($urandom_range(2, 8)), 90, 1'b1, 1'b0);
		run_phase(BYTE_W'($urandom), BYTE_W'($urandom), 8'hFF, 60, 1'b1, 1'b0);
		settle();
	endtask

	// Chain minimal good frames back to back with no idling
	task automatic test_min_frames();
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		cfg_write(REG_HDR_FIRST, 8'h5E);
		cfg_write(REG_HDR_SECOND, 8'hA1);
		cfg_write(REG_PAY_LEN, 8'd1);
		// flush any open frame back to hunting
		send_rx_byte(8'h00);
		send_rx_byte(8'h00);
		send_rx_byte(8'h5E);
		repeat (MIN_FRAMES) begin
			send_rx_byte(8'hA1);
			send_rx_byte(8'h5E);
			send_rx_byte(8'h5E);
		end
		settle();
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_HDR_FIRST;
		cfg_data      = '0;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = '0;
		res_ch.ready  = 1'b0;
		src_idle_en   = 1'b1;
		sink_idle_en  = 1'b1;
		sink_hold     = 0;
		hdr_first_cfg  = '0;
		hdr_second_cfg = '0;
		len_cfg        = LEN_W'(LEN_RESET);
		frm_phase = PH_HUNT;
		frm_prev  = '0;
		frm_pos   = '0;
		frm_sum   = '0;
		frm_good  = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_defaults_and_length_change();
		test_zero_length();
		test_back_to_back();
		test_random_traffic();
		test_min_frames();

		if (pending_results.size() != 0) begin
			error_count++;
			$display("%0d predicted results never arrived", pending_results.size());
		end
		$display("Sent %0d bytes, checked %0d results; %0d frames closed, %0d with a good sum.",
			bytes_sent, results_seen, frames_closed, frames_good);
		$display("Lengths 0 to 127 incl. mid-frame change, chained frames, stalls and hold-off.");
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
